@@ hw/rtl/spoc_pkg.sv @@
// Shared types and constants of the stack pop order checker.
`timescale 1ns / 1ps

package spoc_pkg;

    // Width of each value field on the input stream.
    localparam int FIELD_W = 32;

    // Stream data widths, whole bytes.
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 8;

    // Entries in the queue between the front and the back part.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One input item as it travels through the queue.
    typedef struct packed {
        logic                      last;
        logic signed [FIELD_W-1:0] pop_value;
        logic signed [FIELD_W-1:0] push_value;
    } item_t;

    // One result item.
    typedef struct packed {
        logic too_long;
        logic is_pop_order;
    } result_t;

endpackage

@@ hw/rtl/stack_pop_order_checker.sv @@
// After its last item is accepted, the back part checks the stack and pops each matching value in
// turn, taking the new top and head straight from the RAMs; the result is registered.
// The back part takes no new item until it has finished popping for the last one; pops never
// outnumber pushes, and each pop needs a read from the single read port of each RAM.
// Reset: synchronous, active low; clears the queue, counters and result valid. The stack
// and pop memories are not cleared: data read from an entry not yet written is never used.
`timescale 1ns / 1ps

module stack_pop_order_checker #(
    parameter int MAX_LEN    = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0 up: push_value [31:0], pop_value [63:32].
    input  logic [spoc_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0 up: is_pop_order [0], too_long [1], zeros [7:2].
    output logic [spoc_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    spoc_pkg::item_t   item;
    logic              item_valid;
    logic              item_ready;
    spoc_pkg::result_t result;

    // Input side: unpack and queue items.
    spoc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready)
    );

    // Stack simulation and verdict.
    spoc_back #(
        .MAX_LEN    (MAX_LEN),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .result     (result)
    );

    // Pack the result word.
    assign m_tdata = {{(spoc_pkg::OUT_TDATA_W - 2){1'b0}}, result.too_long,
                      result.is_pop_order};

endmodule

@@ hw/rtl/spoc_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module spoc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/spoc_front.sv @@
// Front part: accepts stream items, unpacks them and queues them for the back part.
`timescale 1ns / 1ps

module spoc_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // Fields from bit 0 up: push_value [31:0], pop_value [63:32].
    input  logic [spoc_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                               s_tlast,
    output spoc_pkg::item_t                    item,
    output logic                               item_valid,
    input  logic                               item_ready
);

    spoc_pkg::item_t                   queue_mem [spoc_pkg::QUEUE_DEPTH];
    spoc_pkg::item_t                   in_item;
    logic [spoc_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [spoc_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [spoc_pkg::QCNT_W-1:0]       count_reg;
    logic                              push;
    logic                              pop;

    // Unpack the stream word into the item fields.
    always_comb begin
        in_item.push_value = s_tdata[spoc_pkg::FIELD_W-1:0];
        in_item.pop_value  = s_tdata[2*spoc_pkg::FIELD_W-1:spoc_pkg::FIELD_W];
        in_item.last       = s_tlast;
    end

    assign s_tready   = (count_reg != spoc_pkg::QCNT_W'(spoc_pkg::QUEUE_DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = queue_mem[rd_ptr_reg];
    assign push       = s_tvalid && s_tready;
    assign pop        = item_valid && item_ready;

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= in_item;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + spoc_pkg::QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + spoc_pkg::QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + spoc_pkg::QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - spoc_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

@@ hw/rtl/spoc_back.sv @@
// Back part: stores pop values, runs the stack and issues the verdict.
`timescale 1ns / 1ps

module spoc_back #(
    parameter int MAX_LEN    = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  spoc_pkg::item_t     item,
    input  logic                item_valid,
    output logic                item_ready,
    output logic                res_valid,
    input  logic                res_ready,
    output spoc_pkg::result_t   result
);

    localparam int STORE_W = (VALUE_BITS < spoc_pkg::FIELD_W) ? VALUE_BITS
                                                              : spoc_pkg::FIELD_W;
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEN);

    // Sequencer states.
    localparam logic [1:0] ST_PUSH  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_FETCH = 2'd2;

    logic [1:0]         state_reg;
    logic [CW-1:0]      depth_reg;
    logic [CW-1:0]      pop_idx_reg;
    logic [CW-1:0]      pair_cnt_reg;
    logic               overflow_reg;
    logic               res_valid_reg;
    spoc_pkg::result_t  result_reg;
    logic               last_reg;
    logic [STORE_W-1:0] top_reg;
    logic [STORE_W-1:0] head_reg;

    logic [STORE_W-1:0] push_val;
    logic [STORE_W-1:0] pop_val;
    logic [STORE_W-1:0] stk_rdata;
    logic [STORE_W-1:0] pop_rdata;
    logic [STORE_W-1:0] cmp_top;
    logic [STORE_W-1:0] cmp_head;
    logic [CW-1:0]      depth_m2;
    logic [CW-1:0]      pop_idx_p1;
    logic               take;
    logic               room;
    logic               busy;
    logic               can_pop;
    logic               out_free;
    logic               wr_en;

    assign push_val   = item.push_value[STORE_W-1:0];
    assign pop_val    = item.pop_value[STORE_W-1:0];
    assign item_ready = (state_reg == ST_PUSH);
    assign take       = item_ready && item_valid;
    assign room       = (pair_cnt_reg != MAX_CNT);
    assign wr_en      = take && room;
    assign busy       = (state_reg == ST_CHECK) || (state_reg == ST_FETCH);

    // Right after a pop the new top and head come straight from the RAMs.
    assign cmp_top  = (state_reg == ST_FETCH) ? stk_rdata : top_reg;
    assign cmp_head = (state_reg == ST_FETCH) ? pop_rdata : head_reg;
    assign can_pop  = busy && (depth_reg != '0) && (pop_idx_reg < pair_cnt_reg) &&
                      (cmp_top == cmp_head);

    assign depth_m2   = depth_reg - CW'(2);
    assign pop_idx_p1 = pop_idx_reg + CW'(1);
    assign out_free   = !res_valid_reg || res_ready;

    assign res_valid = res_valid_reg;
    assign result    = result_reg;

    // Stack entries, indexed by depth.
    spoc_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (depth_reg[AW-1:0]),
        .wr_data (push_val),
        .rd_en   (can_pop),
        .rd_addr (depth_m2[AW-1:0]),
        .rd_data (stk_rdata)
    );

    // Received pop values, indexed by arrival order.
    spoc_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_pop_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (pair_cnt_reg[AW-1:0]),
        .wr_data (pop_val),
        .rd_en   (can_pop),
        .rd_addr (pop_idx_p1[AW-1:0]),
        .rd_data (pop_rdata)
    );

    // Sequencer and counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_PUSH;
            depth_reg     <= '0;
            pop_idx_reg   <= '0;
            pair_cnt_reg  <= '0;
            overflow_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (res_valid_reg && res_ready) begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_PUSH: begin
                    if (item_valid) begin
                        if (room) begin
                            depth_reg    <= depth_reg + CW'(1);
                            pair_cnt_reg <= pair_cnt_reg + CW'(1);
                        end else begin
                            overflow_reg <= 1'b1;
                        end
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK, ST_FETCH: begin
                    if (can_pop) begin
                        depth_reg   <= depth_reg - CW'(1);
                        pop_idx_reg <= pop_idx_p1;
                        state_reg   <= ST_FETCH;
                    end else if (!last_reg) begin
                        state_reg <= ST_PUSH;
                    end else if (out_free) begin
                        // End of the sequences: report and start over.
                        res_valid_reg <= 1'b1;
                        depth_reg     <= '0;
                        pop_idx_reg   <= '0;
                        pair_cnt_reg  <= '0;
                        overflow_reg  <= 1'b0;
                        state_reg     <= ST_PUSH;
                    end
                end
                default: begin
                    state_reg <= ST_PUSH;
                end
            endcase
        end
    end

    // Cached top of stack, cached pop head and the result word.
    always_ff @(posedge aclk) begin
        if (take) begin
            last_reg <= item.last;
            if (room) begin
                top_reg <= push_val;
                // With every pop value matched, the new one becomes the head.
                if (pop_idx_reg == pair_cnt_reg) begin
                    head_reg <= pop_val;
                end
            end
        end
        if (state_reg == ST_FETCH) begin
            top_reg  <= stk_rdata;
            head_reg <= pop_rdata;
        end
        if (busy && !can_pop && last_reg && out_free) begin
            result_reg.too_long     <= overflow_reg;
            result_reg.is_pop_order <= !overflow_reg && (depth_reg == '0);
        end
    end

endmodule

@@ tb/tb_stack_pop_order_checker.sv @@
// Self-checking testbench for the stack pop order checker, with stream driver and monitor.
`timescale 1ns / 1ps

module tb_stack_pop_order_checker;

    localparam int MAX_PAIRS    = 1024;
    localparam int RANDOM_ITEMS = 530;
    localparam int HOLD_START   = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int CALM_FROM    = 900;
    localparam int CALM_TO      = 1300;
    localparam int DRAIN_CYCLES = 40;
    localparam int IDLE_PCT     = 19;

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [spoc_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                             s_tlast  = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [spoc_pkg::OUT_TDATA_W-1:0] m_tdata;

    // Shadow copy of the stack checker state.
    logic [spoc_pkg::FIELD_W-1:0] shadow_stack [MAX_PAIRS];
    logic [spoc_pkg::FIELD_W-1:0] shadow_pops  [MAX_PAIRS];
    int                           shadow_depth;
    int                           shadow_pop_idx;
    int                           shadow_pairs;
    bit                           shadow_overflow;

    spoc_pkg::item_t              pending_items[$];
    spoc_pkg::result_t            verdict_q[$];
    logic [spoc_pkg::FIELD_W-1:0] seq_push[$];
    logic [spoc_pkg::FIELD_W-1:0] seq_pop[$];
    int                           err_cnt   = 0;
    int                           cyc       = 0;
    int                           hold_left = 0;

    stack_pop_order_checker #(
        .MAX_LEN    (MAX_PAIRS),
        .VALUE_BITS (spoc_pkg::FIELD_W)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cyc <= cyc + 1;
    end

    // Both sides run without idling inside this window of cycles.
    function automatic bit calm(input int c);
        return c >= CALM_FROM && c < CALM_TO;
    endfunction

    function automatic void note_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    // Apply one accepted pair to the shadow stack; a last pair yields the verdict.
    function automatic void track_pair(input logic [spoc_pkg::FIELD_W-1:0] push_v,
                                       input logic [spoc_pkg::FIELD_W-1:0] pop_v,
                                       input logic is_last);
        spoc_pkg::result_t verdict;
        if (shadow_pairs >= MAX_PAIRS) begin
            shadow_overflow = 1'b1;
        end else begin
            shadow_pops[shadow_pairs] = pop_v;
            shadow_pairs++;
            shadow_stack[shadow_depth] = push_v;
            shadow_depth++;
            // Greedy pop against pop values already received.
            while (shadow_depth > 0 && shadow_pop_idx < shadow_pairs &&
                   shadow_stack[shadow_depth-1] == shadow_pops[shadow_pop_idx]) begin
                shadow_depth--;
                shadow_pop_idx++;
            end
        end
        if (is_last) begin
            verdict.too_long     = shadow_overflow;
            verdict.is_pop_order = !shadow_overflow && shadow_depth == 0;
            verdict_q.push_back(verdict);
            shadow_depth    = 0;
            shadow_pop_idx  = 0;
            shadow_pairs    = 0;
            shadow_overflow = 1'b0;
        end
    endfunction

    // Mix of wide random values, a small pool that repeats, and the extremes.
    function automatic logic [spoc_pkg::FIELD_W-1:0] pick_value();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom();
            4, 5, 6:    return $urandom_range(7);
            7:          return 32'h8000_0000;
            8:          return 32'h7fff_ffff;
            default:    return 32'hffff_ffff;
        endcase
    endfunction

    // Turn the scratch sequences into items, the final pair marked last.
    task automatic flush_sequence();
        spoc_pkg::item_t it;
        for (int k = 0; k < seq_push.size(); k++) begin
            it.push_value = seq_push[k];
            it.pop_value  = seq_pop[k];
            it.last       = (k == seq_push.size() - 1);
            pending_items.push_back(it);
        end
    endtask

    // Build a push sequence and a pop order reached by a random push/pop walk;
    // a broken one is then damaged by a swap, a changed value or random values.
    task automatic build_sequence(input int n, input bit broken);
        logic [spoc_pkg::FIELD_W-1:0] stk[$];
        logic [spoc_pkg::FIELD_W-1:0] tmp;
        int pushed;
        int a;
        int b;
        seq_push.delete();
        seq_pop.delete();
        pushed = 0;
        for (int k = 0; k < n; k++) begin
            seq_push.push_back(pick_value());
        end
        while (seq_pop.size() < n) begin
            if (pushed < n && (stk.size() == 0 || $urandom_range(1) == 1)) begin
                stk.push_back(seq_push[pushed]);
                pushed++;
            end else begin
                seq_pop.push_back(stk.pop_back());
            end
        end
        if (broken) begin
            a = $urandom_range(n - 1);
            b = $urandom_range(n - 1);
            case ($urandom_range(2))
                0: begin
                    tmp        = seq_pop[a];
                    seq_pop[a] = seq_pop[b];
                    seq_pop[b] = tmp;
                end
                1: begin
                    seq_pop[a] = pick_value();
                end
                default: begin
                    for (int k = 0; k < n; k++) begin
                        seq_pop[k] = pick_value();
                    end
                end
            endcase
        end
    endtask

    // Driver: predicts on each accepted item, then offers the next one or idles.
    always @(posedge aclk) begin : drive
        spoc_pkg::item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                track_pair(s_tdata[spoc_pkg::FIELD_W-1:0],
                           s_tdata[2*spoc_pkg::FIELD_W-1:spoc_pkg::FIELD_W], s_tlast);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() > 0 &&
                    (calm(cyc) || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {nxt.pop_value, nxt.push_value};
                    s_tlast  <= nxt.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result item and stalls at random, once for a long stretch.
    always @(posedge aclk) begin : watch
        spoc_pkg::result_t want;
        spoc_pkg::result_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[1:0];
                if (verdict_q.size() == 0) begin
                    note_error($sformatf("result with none expected, tdata %b", m_tdata));
                end else begin
                    want = verdict_q.pop_front();
                    if (got.is_pop_order !== want.is_pop_order ||
                        got.too_long !== want.too_long) begin
                        note_error($sformatf(
                            "is_pop_order exp %0b got %0b, too_long exp %0b got %0b",
                            want.is_pop_order, got.is_pop_order,
                            want.too_long, got.too_long));
                    end
                end
            end
            if (cyc == HOLD_START) begin
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm(cyc) || $urandom_range(99) >= IDLE_PCT;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin : stimulus
        int  sent;
        int  len;
        shadow_depth    = 0;
        shadow_pop_idx  = 0;
        shadow_pairs    = 0;
        shadow_overflow = 1'b0;

        // Single pairs: zero against zero, and extremes that differ.
        seq_push = '{32'd0};
        seq_pop  = '{32'd0};
        flush_sequence();
        seq_push = '{32'h7fff_ffff};
        seq_pop  = '{32'h8000_0000};
        flush_sequence();
        // Reverse order is a pop order; a crossed one is not.
        seq_push = '{32'd1, 32'd2, 32'd3};
        seq_pop  = '{32'd3, 32'd2, 32'd1};
        flush_sequence();
        seq_push = '{32'd1, 32'd2, 32'd3};
        seq_pop  = '{32'd3, 32'd1, 32'd2};
        flush_sequence();
        // Zero pop values in the middle must not end the matching.
        seq_push = '{32'd0, 32'd5, 32'd0};
        seq_pop  = '{32'd0, 32'd0, 32'd5};
        flush_sequence();
        // Popping stops when every received pop value has been matched.
        seq_push = '{32'd7, 32'd7};
        seq_pop  = '{32'd7, 32'd7};
        flush_sequence();
        seq_push = '{32'd4, 32'd9};
        seq_pop  = '{32'd9, 32'd4};
        flush_sequence();
        // Extreme values pushed and popped in reverse.
        seq_push = '{32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff};
        seq_pop  = '{32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000};
        flush_sequence();
        // Repeated values under the greedy rule.
        seq_push = '{32'd1, 32'd1, 32'd2};
        seq_pop  = '{32'd1, 32'd2, 32'd1};
        flush_sequence();

        // Random sequences, mostly valid orders.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            build_sequence(len, $urandom_range(99) < 30);
            flush_sequence();
            sent += len;
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() > 0 || s_tvalid) @(negedge aclk);
        while (verdict_q.size() > 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/spoc_pkg.sv
hw/rtl/spoc_ram.sv
hw/rtl/spoc_front.sv
hw/rtl/spoc_back.sv
hw/rtl/stack_pop_order_checker.sv
tb/tb_stack_pop_order_checker.sv
